// ===== src/sal_pkg.sv =====
package sal_pkg;

  localparam int unsigned DepthDef = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PosW     = 3;
  localparam int unsigned FillW    = 4;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_DELETED  = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_EMPTY    = 3'd4,
    STAT_ENTRY    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_DEL_RD,
    ST_DEL_CMP,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_OUT_RD,
    ST_OUT_EMIT,
    ST_EMIT
  } state_e;

endpackage

// ===== src/sorted_array_list.sv =====
// Sorted list of up to DEPTH signed 32-bit values kept in ascending order in a
// single-port-write, single-port-read array. Request kind on s_axis_tuser:
// insert, delete, or read out all entries. Each compare/move step reads the
// array through its registered read port and then compares or writes, so an
// insert steps once per entry above the insert point, a delete once per entry
// scanned and once per entry moved down, and a readout once per stored entry;
// output back-pressure can stall a readout or a result. The block takes no new
// beat until the last result of the current request has been loaded into the
// output register; insert and delete give one result, a readout gives one per
// entry (tlast on the final one) or a single empty result. Stored entries need
// no clearing after reset; only state, count, index and m_valid are reset.
module sorted_array_list #(
  parameter int unsigned DEPTH = sal_pkg::DepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [31:0]             s_axis_tdata,  // item_value
  input  logic [1:0]              s_axis_tuser,  // req_type
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [39:0]             m_axis_tdata,  // entry_value, entry_position,
                                                 // fill_count, zero pad
  output logic [2:0]              m_axis_tuser,  // status
  output logic                    m_axis_tlast
);
  import sal_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  status_e status_q, status_d;
  logic signed [DataW-1:0] val_q, val_d;

  logic signed [DataW-1:0] mem [DEPTH];
  logic signed [DataW-1:0] rdata_q;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic signed [DataW-1:0] mem_wdata;

  logic out_free, out_load, out_last;
  status_e out_status;
  logic signed [DataW-1:0] out_value;
  logic [CW-1:0] out_pos;
  logic [7:0] out_pos_w, out_fill_w;

  logic m_valid_q;
  status_e m_status_q;
  logic signed [DataW-1:0] m_value_q;
  logic [PosW-1:0] m_pos_q;
  logic [FillW-1:0] m_fill_q;
  logic m_last_q;

  logic [CW-1:0] idx_inc, idx_dec;
  logic accept;
  logic is_last_entry;

  assign idx_inc       = CW'(idx_q + 1'b1);
  assign idx_dec       = CW'(idx_q - 1'b1);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign is_last_entry = (idx_inc == cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            REQ_INSERT: state_d = (cnt_q == DepthC) ? ST_EMIT : ST_INS_RD;
            REQ_DELETE: state_d = (cnt_q == '0) ? ST_EMIT : ST_DEL_RD;
            REQ_READ:   state_d = (cnt_q == '0) ? ST_EMIT : ST_OUT_RD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD:   state_d = (idx_q == '0) ? ST_EMIT : ST_INS_CMP;
      ST_INS_CMP:  state_d = (rdata_q > val_q) ? ST_INS_RD : ST_EMIT;
      ST_DEL_RD:   state_d = ST_DEL_CMP;
      ST_DEL_CMP: begin
        if (rdata_q == val_q) begin
          state_d = ST_SHF_RD;
        end else begin
          state_d = is_last_entry ? ST_EMIT : ST_DEL_RD;
        end
      end
      ST_SHF_RD:   state_d = (idx_q < cnt_q) ? ST_SHF_WR : ST_EMIT;
      ST_SHF_WR:   state_d = ST_SHF_RD;
      ST_OUT_RD:   state_d = ST_OUT_EMIT;
      ST_OUT_EMIT: begin
        if (out_free) begin
          state_d = is_last_entry ? ST_IDLE : ST_OUT_RD;
        end
      end
      ST_EMIT:     state_d = out_free ? ST_IDLE : ST_EMIT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    status_d   = status_q;
    val_d      = val_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q[AW-1:0];
    mem_wdata  = val_q;
    mem_re     = 1'b0;
    mem_raddr  = idx_q[AW-1:0];
    out_load   = 1'b0;
    out_status = status_q;
    out_value  = '0;
    out_pos    = pos_q;
    out_last   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d = s_axis_tdata;
          pos_d = '0;
          idx_d = '0;
          case (s_axis_tuser)
            REQ_INSERT: begin
              status_d = STAT_FULL;
              idx_d    = cnt_q;
            end
            REQ_DELETE,
            REQ_READ:   status_d = STAT_EMPTY;
            default:    status_d = status_q;
          endcase
        end
      end
      ST_INS_RD: begin
        if (idx_q == '0) begin
          mem_we   = 1'b1;
          pos_d    = '0;
          cnt_d    = CW'(cnt_q + 1'b1);
          status_d = STAT_INSERTED;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
        end
      end
      ST_INS_CMP: begin
        // walk down from the top, moving larger entries up one slot
        mem_we = 1'b1;
        if (rdata_q > val_q) begin
          mem_wdata = rdata_q;
          idx_d     = idx_dec;
        end else begin
          pos_d    = idx_q;
          cnt_d    = CW'(cnt_q + 1'b1);
          status_d = STAT_INSERTED;
        end
      end
      ST_DEL_RD: mem_re = 1'b1;
      ST_DEL_CMP: begin
        if (rdata_q == val_q) begin
          pos_d    = idx_q;
          cnt_d    = CW'(cnt_q - 1'b1);
          status_d = STAT_DELETED;
        end else begin
          idx_d = idx_inc;
          if (is_last_entry) begin
            status_d = STAT_NOTFOUND;
          end
        end
      end
      ST_SHF_RD: begin
        // cnt_q already holds the reduced count: stop before the old top
        if (idx_q < cnt_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
        end
      end
      ST_SHF_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
        idx_d     = idx_inc;
      end
      ST_OUT_RD: mem_re = 1'b1;
      ST_OUT_EMIT: begin
        out_status = STAT_ENTRY;
        out_value  = rdata_q;
        out_pos    = idx_q;
        out_last   = is_last_entry;
        if (out_free) begin
          out_load = 1'b1;
          idx_d    = idx_inc;
        end
      end
      ST_EMIT:  out_load = out_free;
      default: ;
    endcase
  end

  assign out_pos_w  = 8'(out_pos);
  assign out_fill_w = 8'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    status_q <= status_d;
    val_q    <= val_d;
    if (out_load) begin
      m_status_q <= out_status;
      m_value_q  <= out_value;
      m_pos_q    <= out_pos_w[PosW-1:0];
      m_fill_q   <= out_fill_w[FillW-1:0];
      m_last_q   <= out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_fill_q, m_pos_q, m_value_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== src/sal_checker.sv =====
module sal_checker #(
  parameter int unsigned DEPTH = sal_pkg::DepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import sal_pkg::*;

  logic entry_beat;
  logic pos_ok;
  assign entry_beat = m_axis_tvalid && (m_axis_tuser == STAT_ENTRY);
  // readout position stays below the reported count; checked only for DEPTH up to 7
  assign pos_ok = (DEPTH > 7) || ({1'b0, m_axis_tdata[34:32]} < m_axis_tdata[38:35]);

  // a real request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_NONE)) |=> !s_axis_tready)
    else $error("accepted request did not drop tready");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !entry_beat) |-> (m_axis_tdata[31:0] == '0))
    else $error("non-readout beat carries a value");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !entry_beat) |-> m_axis_tlast)
    else $error("single result without tlast");

  a_readout_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_beat |-> pos_ok)
    else $error("readout position beyond count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output beat changed");

endmodule

bind sorted_array_list sal_checker #(.DEPTH(DEPTH)) u_sal_checker (.*);
